// File: design/bcpt_pkg.sv
`timescale 1ns / 1ps
// Package for the barycentric point-in-triangle unit: widths, register
// indexes, types and the divider stage record. Depends on nothing.
package bcpt_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;

    localparam int DIFF_W    = COORD_BITS + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int MAG_W     = CROSS_W;
    localparam int REM_W     = MAG_W + 2;
    localparam int QUO_W     = FRAC_BITS + 2;
    localparam int MAGO_W    = FRAC_BITS + 3;
    localparam int WEIGHT_W  = FRAC_BITS + 2;
    localparam int DIV_LAT   = FRAC_BITS + 3;
    localparam int STAGES    = DIV_LAT + 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_A_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_C_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_C_Y = 3'd5;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [CROSS_W-1:0]    cross_t;
    typedef logic        [MAG_W-1:0]      mag_t;
    typedef logic signed [WEIGHT_W-1:0]   weight_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        mag_t             den;
        logic [QUO_W-1:0] quo;
        logic             sat;
        logic             neg;
    } div_stage_t;

endpackage

// File: design/bcpt_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces of the barycentric unit: point, result, config write.
// Depends on bcpt_pkg.
interface bcpt_point_if;
    logic                  valid;
    logic                  ready;
    bcpt_pkg::coord_t      point_x;
    bcpt_pkg::coord_t      point_y;
    modport source (output valid, point_x, point_y, input ready);
    modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface bcpt_result_if;
    logic                  valid;
    logic                  ready;
    bcpt_pkg::weight_t     weight_u;
    bcpt_pkg::weight_t     weight_v;
    bcpt_pkg::weight_t     weight_w;
    logic                  inside_res;
    logic                  degenerate;
    modport source (output valid, weight_u, weight_v, weight_w, inside_res, degenerate,
                    input ready);
    modport sink   (input valid, weight_u, weight_v, weight_w, inside_res, degenerate,
                    output ready);
endinterface

interface bcpt_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bcpt_pkg::CFG_IDX_W-1:0]     index;
    bcpt_pkg::coord_t                   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/barycentric_point_in_triangle.sv
`timescale 1ns / 1ps
// Throughput: one point per cycle while results are taken; the two restoring dividers retire one
// quotient bit per stage, so their depth sets the latency, not the rate.
// The whole pipeline holds while a result beat waits and is not taken.
// Reset clears vertices to zero and empties the pipeline; no clearing pass.
module barycentric_point_in_triangle
(
    input  logic                    clk,
    input  logic                    rst_n,
    bcpt_point_if.sink              point,
    bcpt_cfg_if.sink                cfg,
    bcpt_result_if.source           result
);

    // vertex registers
    bcpt_pkg::coord_t ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg <= '0; ay_reg <= '0;
            bx_reg <= '0; by_reg <= '0;
            cx_reg <= '0; cy_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                bcpt_pkg::REG_A_X: ax_reg <= cfg.data;
                bcpt_pkg::REG_A_Y: ay_reg <= cfg.data;
                bcpt_pkg::REG_B_X: bx_reg <= cfg.data;
                bcpt_pkg::REG_B_Y: by_reg <= cfg.data;
                bcpt_pkg::REG_C_X: cx_reg <= cfg.data;
                bcpt_pkg::REG_C_Y: cy_reg <= cfg.data;
                default: ;  // drop writes past the last register
            endcase
        end
    end

    // Global advance: every stage moves when the output slot is free or drained.
    logic                          adv;
    logic [bcpt_pkg::STAGES-1:0]   valid_pipe_reg;
    logic [bcpt_pkg::STAGES-1:3]   degen_pipe_reg;

    assign adv         = !valid_pipe_reg[bcpt_pkg::STAGES-1] || result.ready;
    assign point.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_pipe_reg <= '0;
        end
        else if (adv)
        begin
            valid_pipe_reg <= {valid_pipe_reg[bcpt_pkg::STAGES-2:0], point.valid};
        end
    end

    // Stage 1: edge vectors relative to vertex a.
    bcpt_pkg::diff_t x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg;
    // Stage 2: the six cross-product terms.
    bcpt_pkg::prod_t p_den0_reg, p_den1_reg, p_v0_reg, p_v1_reg, p_w0_reg, p_w1_reg;
    // Stage 3: doubled area and the two numerators.
    bcpt_pkg::cross_t den_reg, nv_reg, nw_reg;
    // Stage 4: magnitudes and quotient signs for the dividers.
    bcpt_pkg::mag_t   den_mag_reg, nv_mag_reg, nw_mag_reg;
    logic             nv_neg_reg, nw_neg_reg;
    logic             den_zero;
    // Sign-applied weights and the output register.
    bcpt_pkg::weight_t v_reg, w_reg;
    bcpt_pkg::weight_t u_out_reg, v_out_reg, w_out_reg;
    logic              inside_out_reg;

    logic [bcpt_pkg::MAGO_W-1:0] v_mag, w_mag;
    logic                        v_neg, w_neg;

    assign den_zero = (den_reg == '0);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg <= bcpt_pkg::DIFF_W'(bx_reg) - bcpt_pkg::DIFF_W'(ax_reg);
            y0_reg <= bcpt_pkg::DIFF_W'(by_reg) - bcpt_pkg::DIFF_W'(ay_reg);
            x1_reg <= bcpt_pkg::DIFF_W'(cx_reg) - bcpt_pkg::DIFF_W'(ax_reg);
            y1_reg <= bcpt_pkg::DIFF_W'(cy_reg) - bcpt_pkg::DIFF_W'(ay_reg);
            x2_reg <= bcpt_pkg::DIFF_W'(point.point_x) - bcpt_pkg::DIFF_W'(ax_reg);
            y2_reg <= bcpt_pkg::DIFF_W'(point.point_y) - bcpt_pkg::DIFF_W'(ay_reg);

            p_den0_reg <= x0_reg * y1_reg;
            p_den1_reg <= x1_reg * y0_reg;
            p_v0_reg   <= x2_reg * y1_reg;
            p_v1_reg   <= x1_reg * y2_reg;
            p_w0_reg   <= x0_reg * y2_reg;
            p_w1_reg   <= x2_reg * y0_reg;

            den_reg <= bcpt_pkg::CROSS_W'(p_den0_reg) - bcpt_pkg::CROSS_W'(p_den1_reg);
            nv_reg  <= bcpt_pkg::CROSS_W'(p_v0_reg) - bcpt_pkg::CROSS_W'(p_v1_reg);
            nw_reg  <= bcpt_pkg::CROSS_W'(p_w0_reg) - bcpt_pkg::CROSS_W'(p_w1_reg);

            den_mag_reg <= den_reg[bcpt_pkg::CROSS_W-1] ? bcpt_pkg::mag_t'(-den_reg)
                                                        : bcpt_pkg::mag_t'(den_reg);
            nv_mag_reg  <= nv_reg[bcpt_pkg::CROSS_W-1] ? bcpt_pkg::mag_t'(-nv_reg)
                                                       : bcpt_pkg::mag_t'(nv_reg);
            nw_mag_reg  <= nw_reg[bcpt_pkg::CROSS_W-1] ? bcpt_pkg::mag_t'(-nw_reg)
                                                       : bcpt_pkg::mag_t'(nw_reg);
            nv_neg_reg  <= nv_reg[bcpt_pkg::CROSS_W-1] ^ den_reg[bcpt_pkg::CROSS_W-1];
            nw_neg_reg  <= nw_reg[bcpt_pkg::CROSS_W-1] ^ den_reg[bcpt_pkg::CROSS_W-1];

            // The degenerate flag is born at stage 4 and rides along after it.
            for (int i = 4; i < bcpt_pkg::STAGES; i++)
            begin
                degen_pipe_reg[i] <= degen_pipe_reg[i-1];
            end
            degen_pipe_reg[3] <= den_zero;
        end
    end

    // Two divider lanes, one per numerator; a zero divisor yields junk that
    // the degenerate flag masks at the output.
    bcpt_div u_div_v
    (
        .clk     (clk),
        .en      (adv),
        .num     (nv_mag_reg),
        .den     (den_mag_reg),
        .neg_in  (nv_neg_reg),
        .mag     (v_mag),
        .neg_out (v_neg)
    );

    bcpt_div u_div_w
    (
        .clk     (clk),
        .en      (adv),
        .num     (nw_mag_reg),
        .den     (den_mag_reg),
        .neg_in  (nw_neg_reg),
        .mag     (w_mag),
        .neg_out (w_neg)
    );

    // Apply the sign and clamp each quotient to the Q2 range.
    localparam logic [bcpt_pkg::MAGO_W-1:0] MAG_MAX =
        (bcpt_pkg::MAGO_W'(1) << (bcpt_pkg::FRAC_BITS + 1)) - bcpt_pkg::MAGO_W'(1);
    localparam logic [bcpt_pkg::MAGO_W-1:0] MAG_MIN =
        bcpt_pkg::MAGO_W'(1) << (bcpt_pkg::FRAC_BITS + 1);

    function automatic bcpt_pkg::weight_t sign_sat(logic [bcpt_pkg::MAGO_W-1:0] m,
                                                   logic neg);
        logic [bcpt_pkg::MAGO_W-1:0] negm;
        negm = -m;
        if (neg)
        begin
            return (m > MAG_MIN) ? bcpt_pkg::weight_t'(MAG_MIN)
                                 : bcpt_pkg::weight_t'(negm);
        end
        return (m > MAG_MAX) ? bcpt_pkg::weight_t'(MAG_MAX) : bcpt_pkg::weight_t'(m);
    endfunction

    // u = 1 - v - w, clamped; then the inside test on the clamped values.
    localparam int SUM_W = bcpt_pkg::WEIGHT_W + 2;
    localparam logic signed [SUM_W-1:0] ONE_FX   = SUM_W'(1) << bcpt_pkg::FRAC_BITS;
    localparam logic signed [SUM_W-1:0] W_MAX    =
        (SUM_W'(1) << (bcpt_pkg::FRAC_BITS + 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] W_MIN    = -(SUM_W'(1) << (bcpt_pkg::FRAC_BITS + 1));

    logic signed [SUM_W-1:0] u_raw, uv_sum;
    bcpt_pkg::weight_t       u_sat;
    logic                    inside_next;
    logic                    degen_q;

    assign degen_q = degen_pipe_reg[bcpt_pkg::STAGES-2];

    always_comb
    begin
        u_raw = ONE_FX - SUM_W'(v_reg) - SUM_W'(w_reg);
        if (u_raw > W_MAX)
        begin
            u_sat = bcpt_pkg::weight_t'(W_MAX);
        end
        else if (u_raw < W_MIN)
        begin
            u_sat = bcpt_pkg::weight_t'(W_MIN);
        end
        else
        begin
            u_sat = bcpt_pkg::weight_t'(u_raw);
        end
        uv_sum      = SUM_W'(u_sat) + SUM_W'(v_reg);
        inside_next = !u_sat[bcpt_pkg::WEIGHT_W-1] && !v_reg[bcpt_pkg::WEIGHT_W-1]
                   && (uv_sum < ONE_FX);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_reg <= sign_sat(v_mag, v_neg);
            w_reg <= sign_sat(w_mag, w_neg);

            u_out_reg      <= degen_q ? '0 : u_sat;
            v_out_reg      <= degen_q ? '0 : v_reg;
            w_out_reg      <= degen_q ? '0 : w_reg;
            inside_out_reg <= !degen_q && inside_next;
        end
    end

    assign result.valid      = valid_pipe_reg[bcpt_pkg::STAGES-1];
    assign result.weight_u   = u_out_reg;
    assign result.weight_v   = v_out_reg;
    assign result.weight_w   = w_out_reg;
    assign result.inside_res = inside_out_reg;
    assign result.degenerate = degen_pipe_reg[bcpt_pkg::STAGES-1];

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.degenerate |->
            result.weight_u == '0 && result.weight_v == '0 && result.weight_w == '0
            && !result.inside_res)
        else $error("degenerate beat carries nonzero weights or inside");

    a_inside_signs: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.inside_res |->
            !result.weight_u[bcpt_pkg::WEIGHT_W-1] && !result.weight_v[bcpt_pkg::WEIGHT_W-1])
        else $error("inside beat with negative u or v");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_pipe_reg))
        else $error("pipeline moved during a stall");
`endif

endmodule

// File: design/bcpt_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, saturating at 4.
// Depends on bcpt_pkg.
module bcpt_div
(
    input  logic                          clk,
    input  logic                          en,
    input  bcpt_pkg::mag_t                num,
    input  bcpt_pkg::mag_t                den,
    input  logic                          neg_in,
    output logic [bcpt_pkg::MAGO_W-1:0]   mag,
    output logic                          neg_out
);

    bcpt_pkg::div_stage_t st_reg  [0:bcpt_pkg::DIV_LAT-1];
    bcpt_pkg::div_stage_t st_next [0:bcpt_pkg::DIV_LAT-1];

    // entry: flag quotients of four or more
    always_comb
    begin
        st_next[0].rem = bcpt_pkg::REM_W'(num);
        st_next[0].den = den;
        st_next[0].quo = '0;
        st_next[0].sat = ({2'b00, num} >= {den, 2'b00});
        st_next[0].neg = neg_in;
    end

    genvar k;
    generate
        for (k = 0; k < bcpt_pkg::QUO_W; k++)
        begin : g_step
            logic [bcpt_pkg::REM_W-1:0] rem_sh;
            logic [bcpt_pkg::REM_W-1:0] dcmp;
            always_comb
            begin
                if (k == 0)
                begin
                    rem_sh = st_reg[k].rem;
                    dcmp   = {1'b0, st_reg[k].den, 1'b0};
                end
                else if (k == 1)
                begin
                    rem_sh = st_reg[k].rem;
                    dcmp   = {2'b00, st_reg[k].den};
                end
                else
                begin
                    rem_sh = {st_reg[k].rem[bcpt_pkg::REM_W-2:0], 1'b0};
                    dcmp   = {2'b00, st_reg[k].den};
                end
                st_next[k+1]     = st_reg[k];
                st_next[k+1].rem = (rem_sh >= dcmp) ? (rem_sh - dcmp) : rem_sh;
                st_next[k+1].quo[bcpt_pkg::QUO_W-1-k] = (rem_sh >= dcmp);
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < bcpt_pkg::DIV_LAT; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign mag = st_reg[bcpt_pkg::DIV_LAT-1].sat
               ? bcpt_pkg::MAGO_W'(4) << bcpt_pkg::FRAC_BITS
               : {1'b0, st_reg[bcpt_pkg::DIV_LAT-1].quo};
    assign neg_out = st_reg[bcpt_pkg::DIV_LAT-1].neg;

endmodule
